[rtl/idll_pkg.sv]
// Package for the indexed doubly linked list unit: sizes, link encoding,
// opcodes and the control struct that drives one link memory.
// No dependencies.
package idll_pkg;

    localparam int NODES   = 64;
    localparam int IDX_W   = $clog2(NODES);
    localparam int FIELD_W = 7;

    localparam logic [FIELD_W-1:0] LINK_NONE = {FIELD_W{1'b1}};

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_UNLINK = 3'd2,
        OP_LINK   = 3'd3,
        OP_QUERY  = 3'd4
    } opcode_t;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [FIELD_W-1:0] wr_data;
        logic               clr_one;
        logic [IDX_W-1:0]   clr_addr;
        logic               clr_all;
    } mem_ctl_t;

    // Out-of-range indices collapse to none
    function automatic logic [FIELD_W-1:0] to_link(input logic [FIELD_W-1:0] field);
        int v;
        v = int'($signed(field));
        return (v >= 0 && v < NODES) ? field : LINK_NONE;
    endfunction

    function automatic logic is_none(input logic [FIELD_W-1:0] link);
        return link[FIELD_W-1];
    endfunction

endpackage

[rtl/idll_req_if.sv]
// Request channel of the linked list unit: opcode and two node indices.
// Depends on idll_pkg.
interface idll_req_if
    import idll_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [2:0]                opcode;
    logic signed [FIELD_W-1:0] node_a;
    logic signed [FIELD_W-1:0] node_b;

    modport source (output valid, output opcode, output node_a, output node_b, input ready);
    modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

[rtl/idll_rsp_if.sv]
// Response channel of the linked list unit: links of node_a, head and tail.
// Depends on idll_pkg.
interface idll_rsp_if
    import idll_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] prev_index;
    logic signed [FIELD_W-1:0] next_index;
    logic signed [FIELD_W-1:0] head_index;
    logic signed [FIELD_W-1:0] tail_index;

    modport source (output valid, output prev_index, output next_index,
                    output head_index, output tail_index, input ready);
    modport sink   (input valid, input prev_index, input next_index,
                    input head_index, input tail_index, output ready);
endinterface

[rtl/idll_link_mem.sv]
// One link memory (prev or next) with per-entry valid bits; invalid reads as none.
// Registered read, one write, one single-entry clear and a whole-array clear.
// Depends on idll_pkg.
module idll_link_mem
    import idll_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mem_ctl_t           ctl,
    output logic [FIELD_W-1:0] rd_data
);

    logic [FIELD_W-1:0] mem [NODES];
    logic [NODES-1:0]   valid_reg, valid_next;
    logic [FIELD_W-1:0] rd_data_reg;

    // clear of a single entry wins over a write to the same entry
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wr_en)
        begin
            valid_next[ctl.wr_addr] = 1'b1;
        end
        if (ctl.clr_one)
        begin
            valid_next[ctl.clr_addr] = 1'b0;
        end
        if (ctl.clr_all)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= valid_reg[ctl.rd_addr] ? mem[ctl.rd_addr] : LINK_NONE;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/indexed_doubly_linked_list_unit.sv]
// Channel  Dir  Beat
// req      in   opcode, node_a, node_b
// rsp      out  prev_index, next_index, head_index, tail_index
//
// A request beat is taken in idle; its node_a links are read from both link
// memories on that edge. The execute state then applies the operation: one write per
// memory, valid-bit clears, head/tail update, and loads the response register.
// The response register lets the next beat in while it waits.
// Reset (and the clear opcode) resets valid bits at once: no sweep.
// A stalled response holds the unit in the execute cycle.
// Depends on idll_pkg, idll_req_if, idll_rsp_if, idll_link_mem.
module indexed_doubly_linked_list_unit
    import idll_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    idll_req_if.sink   req,
    idll_rsp_if.source rsp
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [FIELD_W-1:0] a_reg, a_next;
    logic [FIELD_W-1:0] b_reg, b_next;
    logic [FIELD_W-1:0] head_reg, head_next;
    logic [FIELD_W-1:0] tail_reg, tail_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [FIELD_W-1:0] prev_out_reg, prev_out_next;
    logic [FIELD_W-1:0] next_out_reg, next_out_next;

    logic               req_fire;
    logic               exec_go;
    logic [FIELD_W-1:0] req_a_link;
    logic [FIELD_W-1:0] pa, na;
    logic               a_none, b_none;
    logic [IDX_W-1:0]   a_idx, b_idx;
    mem_ctl_t           prev_ctl, next_ctl;

    idll_link_mem u_prev_mem (.clk(clk), .rst_n(rst_n), .ctl(prev_ctl), .rd_data(pa));
    idll_link_mem u_next_mem (.clk(clk), .rst_n(rst_n), .ctl(next_ctl), .rd_data(na));

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign exec_go    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign req_a_link = to_link(req.node_a);

    assign a_none = is_none(a_reg);
    assign b_none = is_none(b_reg);
    assign a_idx  = a_reg[IDX_W-1:0];
    assign b_idx  = b_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rsp_valid_next = rsp_valid_reg;
        prev_out_next  = prev_out_reg;
        next_out_next  = next_out_reg;

        prev_ctl         = '0;
        next_ctl         = '0;
        prev_ctl.rd_en   = req_fire;
        prev_ctl.rd_addr = req_a_link[IDX_W-1:0];
        next_ctl.rd_en   = req_fire;
        next_ctl.rd_addr = req_a_link[IDX_W-1:0];

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            op_next    = req.opcode;
            a_next     = req_a_link;
            b_next     = to_link(req.node_b);
            state_next = S_EXEC;
        end

        if (exec_go)
        begin
            prev_out_next = pa;
            next_out_next = na;
            case (op_reg)
                OP_CLEAR:
                begin
                    prev_ctl.clr_all = 1'b1;
                    next_ctl.clr_all = 1'b1;
                    head_next        = LINK_NONE;
                    tail_next        = LINK_NONE;
                    prev_out_next    = LINK_NONE;
                    next_out_next    = LINK_NONE;
                end
                OP_APPEND:
                begin
                    if (!a_none)
                    begin
                        if (is_none(head_reg))
                        begin
                            head_next = a_reg;
                        end
                        if (!is_none(tail_reg))
                        begin
                            next_ctl.wr_en   = 1'b1;
                            next_ctl.wr_addr = tail_reg[IDX_W-1:0];
                            next_ctl.wr_data = a_reg;
                        end
                        prev_ctl.wr_en   = 1'b1;
                        prev_ctl.wr_addr = a_idx;
                        prev_ctl.wr_data = tail_reg;
                        tail_next        = a_reg;
                        prev_out_next    = tail_reg;
                        next_out_next    = (tail_reg == a_reg) ? a_reg : na;
                    end
                end
                OP_UNLINK:
                begin
                    if (!a_none)
                    begin
                        if (!is_none(pa))
                        begin
                            next_ctl.wr_en   = 1'b1;
                            next_ctl.wr_addr = pa[IDX_W-1:0];
                            next_ctl.wr_data = na;
                        end
                        if (!is_none(na))
                        begin
                            prev_ctl.wr_en   = 1'b1;
                            prev_ctl.wr_addr = na[IDX_W-1:0];
                            prev_ctl.wr_data = pa;
                        end
                        if (head_reg == a_reg)
                        begin
                            head_next = na;
                        end
                        if (tail_reg == a_reg)
                        begin
                            tail_next = pa;
                        end
                        prev_ctl.clr_one  = 1'b1;
                        prev_ctl.clr_addr = a_idx;
                        next_ctl.clr_one  = 1'b1;
                        next_ctl.clr_addr = a_idx;
                        prev_out_next     = LINK_NONE;
                        next_out_next     = LINK_NONE;
                    end
                end
                OP_LINK:
                begin
                    if (!a_none)
                    begin
                        next_ctl.wr_en   = 1'b1;
                        next_ctl.wr_addr = a_idx;
                        next_ctl.wr_data = b_reg;
                        next_out_next    = b_reg;
                    end
                    if (!b_none)
                    begin
                        prev_ctl.wr_en   = 1'b1;
                        prev_ctl.wr_addr = b_idx;
                        prev_ctl.wr_data = a_reg;
                        if (b_reg == a_reg)
                        begin
                            prev_out_next = a_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (a_none)
            begin
                prev_out_next = LINK_NONE;
                next_out_next = LINK_NONE;
            end
            rsp_valid_next = 1'b1;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_QUERY;
            a_reg         <= LINK_NONE;
            b_reg         <= LINK_NONE;
            head_reg      <= LINK_NONE;
            tail_reg      <= LINK_NONE;
            rsp_valid_reg <= 1'b0;
            prev_out_reg  <= LINK_NONE;
            next_out_reg  <= LINK_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
            prev_out_reg  <= prev_out_next;
            next_out_reg  <= next_out_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.prev_index = prev_out_reg;
    assign rsp.next_index = next_out_reg;
    assign rsp.head_index = head_reg;
    assign rsp.tail_index = tail_reg;

    a_fire_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == S_EXEC)
        else $error("request beat did not start execution");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response raised outside execution");

    a_exec_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("execution did not load response");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && op_reg == OP_CLEAR) |=> is_none(head_reg) && is_none(tail_reg))
        else $error("clear left head or tail set");

endmodule

[tb/sv/idll_list_checker.sv]
// Response checker for the linked list unit: shadows both link tables, head and tail,
// predicts one response beat per accepted request and compares it field by field.
// Depends on idll_pkg, idll_req_if, idll_rsp_if.
module idll_list_checker
    import idll_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    idll_req_if  req,
    idll_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   responses_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [FIELD_W-1:0] link_t;

    typedef struct packed {
        link_t prev_index;
        link_t next_index;
        link_t head_index;
        link_t tail_index;
    } node_view_t;

    localparam link_t NO_LINK = LINK_NONE;

    link_t      prev_of [NODES];
    link_t      next_of [NODES];
    link_t      head_node;
    link_t      tail_node;
    node_view_t expected_views [$];

    function automatic link_t as_node(input logic [FIELD_W-1:0] raw);
        link_t v;
        v = raw;
        return (v >= 0 && v < NODES) ? v : NO_LINK;
    endfunction

    function automatic void wipe_links();
        for (int i = 0; i < NODES; i++)
        begin
            prev_of[i] = NO_LINK;
            next_of[i] = NO_LINK;
        end
        head_node = NO_LINK;
        tail_node = NO_LINK;
    endfunction

    function automatic node_view_t apply_request(input logic [2:0] op,
                                                 input logic [FIELD_W-1:0] raw_a,
                                                 input logic [FIELD_W-1:0] raw_b);
        link_t      a;
        link_t      b;
        link_t      p;
        link_t      x;
        node_view_t view;
        a = as_node(raw_a);
        b = as_node(raw_b);
        case (op)
            OP_CLEAR:
                wipe_links();
            OP_APPEND:
                if (a != NO_LINK)
                begin
                    if (head_node == NO_LINK)
                        head_node = a;
                    if (tail_node != NO_LINK)
                        next_of[tail_node[IDX_W-1:0]] = a;
                    prev_of[a[IDX_W-1:0]] = tail_node;
                    tail_node = a;
                end
            OP_UNLINK:
                if (a != NO_LINK)
                begin
                    p = prev_of[a[IDX_W-1:0]];
                    x = next_of[a[IDX_W-1:0]];
                    if (p != NO_LINK)
                        next_of[p[IDX_W-1:0]] = x;
                    if (x != NO_LINK)
                        prev_of[x[IDX_W-1:0]] = p;
                    if (head_node == a)
                        head_node = x;
                    if (tail_node == a)
                        tail_node = p;
                    prev_of[a[IDX_W-1:0]] = NO_LINK;
                    next_of[a[IDX_W-1:0]] = NO_LINK;
                end
            OP_LINK:
            begin
                if (a != NO_LINK)
                    next_of[a[IDX_W-1:0]] = b;
                if (b != NO_LINK)
                    prev_of[b[IDX_W-1:0]] = a;
            end
            default: ;
        endcase
        view.prev_index = (a != NO_LINK) ? prev_of[a[IDX_W-1:0]] : NO_LINK;
        view.next_index = (a != NO_LINK) ? next_of[a[IDX_W-1:0]] : NO_LINK;
        view.head_index = head_node;
        view.tail_index = tail_node;
        return view;
    endfunction

    function automatic bit field_ok(input string field, input link_t want, input link_t got);
        if (want !== got)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        return want === got;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        node_view_t want;
        bit         clean;
        if (!rst_n)
        begin
            wipe_links();
            expected_views.delete();
            mismatches        <= 0;
            outstanding       <= 0;
            responses_checked <= 0;
        end
        else
        begin
            // compare before pushing: a beat never answers the request taken on its own edge
            if (rsp.valid && rsp.ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $display("%0t: unexpected response beat, expected none, got %0d %0d %0d %0d",
                             $time, rsp.prev_index, rsp.next_index, rsp.head_index,
                             rsp.tail_index);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want  = expected_views.pop_front();
                    clean = 1'b1;
                    clean &= field_ok("prev_index", want.prev_index, rsp.prev_index);
                    clean &= field_ok("next_index", want.next_index, rsp.next_index);
                    clean &= field_ok("head_index", want.head_index, rsp.head_index);
                    clean &= field_ok("tail_index", want.tail_index, rsp.tail_index);
                    if (!clean)
                        mismatches <= mismatches + 1;
                    responses_checked <= responses_checked + 1;
                end
            end
            if (req.valid && req.ready)
                expected_views.push_back(apply_request(req.opcode, req.node_a, req.node_b));
            outstanding <= expected_views.size();
        end
    end

endmodule

[tb/sv/tb_indexed_doubly_linked_list_unit.sv]
// Top of the linked list unit testbench: clock, reset, request stimulus with bursts
// and pauses, response back-pressure, and the verdict from the checker's count.
// Depends on idll_pkg, idll_req_if, idll_rsp_if, idll_list_checker and the unit.
module tb_indexed_doubly_linked_list_unit
    import idll_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 1925;
    localparam int PAUSE_AT     = 1000;
    localparam int HOLD_AT      = 700;
    localparam int LONG_HOLD    = 300;
    localparam int CALM_FROM    = 1300;
    localparam int CALM_TO      = 1500;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum {DRAIN_FULL, DRAIN_HALF, DRAIN_SPARSE, DRAIN_CADENCE} drain_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    int mismatches;
    int outstanding;
    int responses_checked;
    int cycle_count = 0;
    int sent_count  = 0;
    int burst_left  = 0;
    int op_count [8];
    bit member [NODES];

    idll_req_if req_ch ();
    idll_rsp_if rsp_ch ();

    indexed_doubly_linked_list_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    idll_list_checker list_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .responses_checked (responses_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d beats still expected", $time, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic offer_request(input logic [2:0] op,
                                 input logic [FIELD_W-1:0] a,
                                 input logic [FIELD_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sent_count >= CALM_FROM && sent_count < CALM_TO) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.node_a <= a;
        req_ch.node_b <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
        op_count[op]++;
        if (op == OP_CLEAR)
            member = '{default: 1'b0};
        else if (op == OP_APPEND && !a[FIELD_W-1])
            member[a[IDX_W-1:0]] = 1'b1;
        else if (op == OP_UNLINK && !a[FIELD_W-1])
            member[a[IDX_W-1:0]] = 1'b0;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [FIELD_W-1:0] pick_node(input bit want_member);
        logic [FIELD_W-1:0] n;
        n = FIELD_W'($urandom_range(0, NODES - 1));
        for (int t = 0; t < 8 && member[n[IDX_W-1:0]] != want_member; t++)
            n = FIELD_W'($urandom_range(0, NODES - 1));
        return n;
    endfunction

    function automatic logic [FIELD_W-1:0] any_node();
        return ($urandom_range(0, 9) == 0) ? LINK_NONE : FIELD_W'($urandom_range(0, NODES - 1));
    endfunction

    task automatic run_directed();
        offer_request(OP_QUERY,  7'd0,      7'd63);
        offer_request(OP_APPEND, 7'd0,      7'h40);
        offer_request(OP_APPEND, 7'd63,     LINK_NONE);
        offer_request(OP_APPEND, 7'd5,      7'd0);
        offer_request(OP_QUERY,  7'd63,     7'h3F);
        offer_request(OP_APPEND, LINK_NONE, 7'd1);
        offer_request(OP_APPEND, 7'h40,     7'd2);
        offer_request(OP_UNLINK, 7'd63,     7'h55);
        offer_request(OP_UNLINK, LINK_NONE, 7'h2A);
        offer_request(OP_UNLINK, 7'h41,     7'd3);
        offer_request(OP_LINK,   7'd5,      7'd0);
        offer_request(OP_LINK,   LINK_NONE, 7'd7);
        offer_request(OP_LINK,   7'd9,      LINK_NONE);
        offer_request(OP_LINK,   LINK_NONE, LINK_NONE);
        offer_request(OP_LINK,   7'd10,     7'h7E);
        offer_request(OP_QUERY,  LINK_NONE, 7'd9);
        for (int r = OP_RSVD_FIRST; r <= OP_RSVD_LAST; r++)
            offer_request(r[2:0], 7'd0, 7'd5);
        offer_request(OP_UNLINK, 7'd0,      7'd0);
        offer_request(OP_UNLINK, 7'd5,      7'd0);
        offer_request(OP_CLEAR,  7'd9,      7'd10);
        offer_request(OP_QUERY,  7'd5,      7'd0);
        offer_request(OP_APPEND, 7'd63,     7'd0);
        offer_request(OP_UNLINK, 7'd63,     7'd0);
        offer_request(OP_QUERY,  7'd63,     7'd0);
    endtask

    task automatic random_request();
        int                 r;
        logic [2:0]         op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        r = $urandom_range(0, 999);
        b = FIELD_W'($urandom_range(0, 127));
        if (r < 8)
        begin
            op = OP_CLEAR;
            a  = FIELD_W'($urandom_range(0, 127));
        end
        else if (r < 420)
        begin
            op = OP_APPEND;
            a  = ($urandom_range(0, 99) < 85) ? pick_node(1'b0) : any_node();
        end
        else if (r < 650)
        begin
            op = OP_UNLINK;
            a  = ($urandom_range(0, 99) < 85) ? pick_node(1'b1) : any_node();
        end
        else if (r < 760)
        begin
            op = OP_LINK;
            a  = any_node();
            b  = any_node();
        end
        else if (r < 900)
        begin
            op = OP_QUERY;
            a  = $urandom_range(0, 1) ? pick_node(1'b1) : any_node();
        end
        else if (r < 940)
        begin
            op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            a  = any_node();
        end
        else
        begin
            op = 3'($urandom_range(0, 7));
            a  = FIELD_W'($urandom_range(0, 127));
        end
        offer_request(op, a, b);
    endtask

    initial
    begin
        drain_mode_t mode;
        int          phase_left;
        int          hold_left;
        bit          hold_done;
        bit          rdy;
        mode       = DRAIN_FULL;
        phase_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = drain_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                case (mode)
                    DRAIN_FULL:   rdy = 1'b1;
                    DRAIN_HALF:   rdy = 1'($urandom_range(0, 1));
                    DRAIN_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:      rdy = (phase_left % 5) < 3;
                endcase
            end
            rsp_ch.ready <= rdy;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_QUERY;
        req_ch.node_a = LINK_NONE;
        req_ch.node_b = LINK_NONE;
        op_count      = '{default: 0};
        member        = '{default: 1'b0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PAUSE_AT)
                wait_drained();
            random_request();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d append, %0d unlink, %0d link, %0d query, %0d clear,",
                 sent_count, op_count[OP_APPEND], op_count[OP_UNLINK], op_count[OP_LINK],
                 op_count[OP_QUERY], op_count[OP_CLEAR]);
        $display("%0d unused opcodes; %0d response beats checked, %0d bad beats",
                 op_count[5] + op_count[6] + op_count[7], responses_checked, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[indexed_doubly_linked_list_unit.f]
rtl/idll_pkg.sv
rtl/idll_req_if.sv
rtl/idll_rsp_if.sv
rtl/idll_link_mem.sv
rtl/indexed_doubly_linked_list_unit.sv
tb/sv/idll_list_checker.sv
tb/sv/tb_indexed_doubly_linked_list_unit.sv
